[src/deawr_pkg.sv]
// Shared definitions for the double-ended array with indexed removal.
// Holds default sizes, operation codes and status codes; no dependencies.
`default_nettype none

package deawr_pkg;

  localparam int DEFAULT_DEPTH      = 64;
  localparam int DEFAULT_ELEM_WIDTH = 8;

  localparam int MODE_W   = 3;
  localparam int STATUS_W = 2;

  localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
  localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_REMOVE_AT  = 3'd4;
  localparam logic [MODE_W-1:0] MODE_READ_AT    = 3'd5;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

endpackage

`default_nettype wire

[src/deawr_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Standalone; no package dependencies.
`default_nettype none

module deawr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[src/double_ended_array_with_removal.sv]
// Top level of the double-ended array with indexed removal.
// Depends on deawr_pkg and deawr_ram.
//
// Usage: drive mode, value and position and raise start; the command is taken
// at a rising edge where start is high and busy is low. Every transaction gives
// exactly one result, shown on read_value, count and status for the single
// cycle in which done is high. The receiver cannot stall; it must take each
// result in its done cycle.
// Timing: push, pop and no-op commands give their result in the cycle after
// acceptance and leave busy low, so one such command can be taken every
// cycle. A read at an index passes through the S_READ state, since the
// element RAM has registered read data. A remove at index p walks the
// elements behind p in the S_SHIFT state: the shift loop moves one element
// per cycle through the RAM, reading the next slot while writing the previous
// one. An out-of-range remove or read is answered like a push, with STATUS_EMPTY.
// Reset (synchronous, active high) empties the array and clears busy and done;
// the RAM contents are not cleared, and no entry's data is used before it is written.
`default_nettype none

module double_ended_array_with_removal #(
  parameter int DEPTH      = deawr_pkg::DEFAULT_DEPTH,
  parameter int ELEM_WIDTH = deawr_pkg::DEFAULT_ELEM_WIDTH
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic [deawr_pkg::MODE_W-1:0]     mode,
  input  wire logic [ELEM_WIDTH-1:0]            value,
  input  wire logic [$clog2(DEPTH)-1:0]         position,
  output logic                                  done,
  output logic      [ELEM_WIDTH-1:0]            read_value,
  output logic      [$clog2(DEPTH+1)-1:0]       count,
  output logic      [deawr_pkg::STATUS_W-1:0]   status
);

  import deawr_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_READ  = 2'd1;
  localparam logic [1:0] S_SHIFT = 2'd2;

  function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] a,
                                                input logic [PTR_W-1:0] b);
    logic [PTR_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (PTR_W+1)'(DEPTH)) begin
      s = s - (PTR_W+1)'(DEPTH);
    end
    return s[PTR_W-1:0];
  endfunction

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] a);
    return (a == PTR_W'(DEPTH - 1)) ? '0 : a + PTR_W'(1);
  endfunction

  function automatic logic [PTR_W-1:0] wrap_dec(input logic [PTR_W-1:0] a);
    return (a == '0) ? PTR_W'(DEPTH - 1) : a - PTR_W'(1);
  endfunction

  logic [1:0]            state;
  logic [PTR_W-1:0]      head;
  logic [CNT_W-1:0]      cnt;
  logic [PTR_W-1:0]      rd_slot;
  logic [PTR_W-1:0]      pend_slot;
  logic                  pend;
  logic [CNT_W-1:0]      remaining;

  logic                  accept;
  logic                  full;
  logic                  empty;
  logic                  pos_ok;
  logic [PTR_W-1:0]      slot_pos;
  logic [PTR_W-1:0]      head_dec;
  logic [PTR_W-1:0]      tail;

  logic                  ram_we;
  logic [PTR_W-1:0]      ram_waddr;
  logic [ELEM_WIDTH-1:0] ram_wdata;
  logic [PTR_W-1:0]      ram_raddr;
  logic [ELEM_WIDTH-1:0] ram_rdata;

  assign busy     = (state != S_IDLE);
  assign accept   = start && !busy;
  assign count    = cnt;
  assign full     = (cnt == CNT_W'(DEPTH));
  assign empty    = (cnt == '0);
  assign pos_ok   = (CNT_W'(position) < cnt);
  assign slot_pos = wrap_add(head, position);
  assign head_dec = wrap_dec(head);
  // Tail slot is only used when not full, so count fits the pointer width.
  assign tail     = wrap_add(head, cnt[PTR_W-1:0]);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = tail;
    ram_wdata = value;
    ram_raddr = slot_pos;
    unique case (state)
      S_IDLE: begin
        if (accept && !full) begin
          if (mode == MODE_PUSH_FRONT) begin
            ram_we    = 1'b1;
            ram_waddr = head_dec;
          end else if (mode == MODE_PUSH_BACK) begin
            ram_we    = 1'b1;
            ram_waddr = tail;
          end
        end
      end
      S_SHIFT: begin
        // Read the next source slot while the previous element lands one slot lower.
        ram_raddr = rd_slot;
        if (pend) begin
          ram_we    = 1'b1;
          ram_waddr = pend_slot;
          ram_wdata = ram_rdata;
        end
      end
      default: begin
      end
    endcase
  end

  deawr_ram #(
    .WIDTH(ELEM_WIDTH),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      cnt   <= '0;
      done  <= 1'b0;
      pend  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            done       <= 1'b1;
            status     <= STATUS_OK;
            read_value <= '0;
            unique case (mode)
              MODE_PUSH_FRONT: begin
                if (full) begin
                  status <= STATUS_FULL;
                end else begin
                  head <= head_dec;
                  cnt  <= cnt + CNT_W'(1);
                end
              end
              MODE_PUSH_BACK: begin
                if (full) begin
                  status <= STATUS_FULL;
                end else begin
                  cnt <= cnt + CNT_W'(1);
                end
              end
              MODE_POP_FRONT: begin
                if (empty) begin
                  status <= STATUS_EMPTY;
                end else begin
                  head <= wrap_inc(head);
                  cnt  <= cnt - CNT_W'(1);
                end
              end
              MODE_POP_BACK: begin
                if (empty) begin
                  status <= STATUS_EMPTY;
                end else begin
                  cnt <= cnt - CNT_W'(1);
                end
              end
              MODE_REMOVE_AT: begin
                if (!pos_ok) begin
                  status <= STATUS_EMPTY;
                end else begin
                  done      <= 1'b0;
                  state     <= S_SHIFT;
                  rd_slot   <= wrap_inc(slot_pos);
                  pend      <= 1'b0;
                  remaining <= cnt - CNT_W'(1) - CNT_W'(position);
                end
              end
              MODE_READ_AT: begin
                if (!pos_ok) begin
                  status <= STATUS_EMPTY;
                end else begin
                  done  <= 1'b0;
                  state <= S_READ;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_READ: begin
          done       <= 1'b1;
          status     <= STATUS_OK;
          read_value <= ram_rdata;
          state      <= S_IDLE;
        end
        S_SHIFT: begin
          if (remaining != '0) begin
            rd_slot   <= wrap_inc(rd_slot);
            pend_slot <= wrap_dec(rd_slot);
            pend      <= 1'b1;
            remaining <= remaining - CNT_W'(1);
          end else begin
            // The last pending element is written back in this same cycle.
            pend       <= 1'b0;
            cnt        <= cnt - CNT_W'(1);
            done       <= 1'b1;
            status     <= STATUS_OK;
            read_value <= '0;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
